/* rtl/core/egs_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// egs_pkg
// shared types and constants of the emboss gray stream unit
// ----------------------------------------------------------------------------
package egs_pkg;

   localparam int DEFAULT_MAX_WIDTH = 1024;

   localparam int PIXEL_W      = 32;
   localparam int RGB_W        = 24;
   localparam int CHAN_W       = 8;
   localparam int WIDTH_REG_W  = 11;
   localparam int HEIGHT_REG_W = 13;
   localparam int ROW_W        = 12;

   localparam int CSR_ADDR_W   = 3;
   localparam int CSR_DATA_W   = 32;

   localparam logic [WIDTH_REG_W-1:0]  WIDTH_RESET  = 11'd1024;
   localparam logic [HEIGHT_REG_W-1:0] HEIGHT_RESET = 13'd1;
   localparam logic [HEIGHT_REG_W-1:0] MAX_HEIGHT   = 13'd4096;

   localparam logic [CHAN_W-1:0] GRAY_MID = 8'd128;
   localparam logic [CHAN_W-1:0] GRAY_MAX = 8'hFF;

   // register index, taken from paddr bit 2
   typedef enum logic {
      REG_IMAGE_WIDTH  = 1'b0,
      REG_IMAGE_HEIGHT = 1'b1
   } reg_index_type;

   // position flags of the current item in the frame
   typedef struct packed {
      logic border;     // first row or first column
      logic row_end;    // last pixel of its row
      logic frame_end;  // last pixel of the frame
   } raster_flags_type;

endpackage : egs_pkg
`default_nettype wire

/* rtl/core/egs_line_store.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// egs_line_store
// previous-row rgb memory, one read-first read/write access per cycle
// ----------------------------------------------------------------------------
module egs_line_store
   import egs_pkg::*;
#(
   parameter int MAX_WIDTH = DEFAULT_MAX_WIDTH
) (
   input  wire logic                         clock,
   input  wire logic                         access,
   input  wire logic [$clog2(MAX_WIDTH)-1:0] addr,
   input  wire logic [RGB_W-1:0]             wdata,
   output logic      [RGB_W-1:0]             rdata
);

   logic [RGB_W-1:0] mem [MAX_WIDTH];
   logic [RGB_W-1:0] rdata_ff;

   // old entry comes out, new entry goes in at the same edge
   always_ff @(posedge clock) begin
      if (access) begin
         rdata_ff   <= mem[addr];
         mem[addr]  <= wdata;
      end
   end

   assign rdata = rdata_ff;

endmodule : egs_line_store
`default_nettype wire

/* rtl/core/egs_gray_calc.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// egs_gray_calc
// largest-magnitude channel difference, offset by 128 and clamped; 128 on border
// ----------------------------------------------------------------------------
module egs_gray_calc
   import egs_pkg::*;
(
   input  wire logic [RGB_W-1:0]  neighbour_rgb,
   input  wire logic [RGB_W-1:0]  pixel_rgb,
   input  wire logic              border,
   output logic      [CHAN_W-1:0] gray
);

   logic signed [CHAN_W:0]   dr, dg, db, diff;
   logic        [CHAN_W-1:0] mr, mg, mb;
   logic signed [CHAN_W+1:0] sum;

   function automatic logic [CHAN_W-1:0] mag_of(input logic signed [CHAN_W:0] d);
      logic signed [CHAN_W:0] n;
      begin
         n = -d;
         mag_of = d[CHAN_W] ? n[CHAN_W-1:0] : d[CHAN_W-1:0];
      end
   endfunction

   always_comb begin
      dr = $signed({1'b0, neighbour_rgb[23:16]}) - $signed({1'b0, pixel_rgb[23:16]});
      dg = $signed({1'b0, neighbour_rgb[15:8]})  - $signed({1'b0, pixel_rgb[15:8]});
      db = $signed({1'b0, neighbour_rgb[7:0]})   - $signed({1'b0, pixel_rgb[7:0]});
      mr = mag_of(dr);
      mg = mag_of(dg);
      mb = mag_of(db);
      // red wins ties, then green
      if (mr >= mg && mr >= mb) begin
         diff = dr;
      end else if (mg >= mb) begin
         diff = dg;
      end else begin
         diff = db;
      end
      sum = $signed({2'b00, GRAY_MID}) + {diff[CHAN_W], diff};
      if (border) begin
         gray = GRAY_MID;
      end else if (sum[CHAN_W+1]) begin
         gray = '0;
      end else if (sum[CHAN_W]) begin
         gray = GRAY_MAX;
      end else begin
         gray = sum[CHAN_W-1:0];
      end
   end

endmodule : egs_gray_calc
`default_nettype wire

/* rtl/core/egs_raster_ctr.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// egs_raster_ctr
// column and row counters with border, end-of-row and end-of-frame flags
// ----------------------------------------------------------------------------
module egs_raster_ctr
   import egs_pkg::*;
#(
   parameter int MAX_WIDTH = DEFAULT_MAX_WIDTH
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         advance,
   input  wire logic [WIDTH_REG_W-1:0]       image_width,
   input  wire logic [HEIGHT_REG_W-1:0]      image_height,
   output logic      [$clog2(MAX_WIDTH)-1:0] column,
   output raster_flags_type                  flags
);

   localparam int CW = $clog2(MAX_WIDTH);
   localparam int LW = (CW + 1 > WIDTH_REG_W) ? CW + 1 : WIDTH_REG_W;

   logic [CW-1:0]           col_ff, col_in;
   logic [ROW_W-1:0]        row_ff, row_in;
   logic [LW-1:0]           w_ext;
   logic [CW:0]             w_sat, col_next;
   logic [HEIGHT_REG_W-1:0] h_sat, row_next;

   always_comb begin
      w_ext = LW'(image_width);
      if (image_width == '0) begin
         w_sat = (CW+1)'(1);
      end else if (w_ext > LW'(MAX_WIDTH)) begin
         w_sat = (CW+1)'(MAX_WIDTH);
      end else begin
         w_sat = w_ext[CW:0];
      end

      if (image_height == '0) begin
         h_sat = HEIGHT_REG_W'(1);
      end else if (image_height > MAX_HEIGHT) begin
         h_sat = MAX_HEIGHT;
      end else begin
         h_sat = image_height;
      end

      col_next = {1'b0, col_ff} + (CW+1)'(1);
      row_next = {1'b0, row_ff} + HEIGHT_REG_W'(1);

      // a counter at or past its bound counts as the last position
      flags.row_end   = (col_next >= w_sat);
      flags.frame_end = flags.row_end && (row_next >= h_sat);
      flags.border    = (row_ff == '0) || (col_ff == '0);

      col_in = col_ff;
      row_in = row_ff;
      if (advance) begin
         if (flags.row_end) begin
            col_in = '0;
            row_in = flags.frame_end ? '0 : row_next[ROW_W-1:0];
         end else begin
            col_in = col_next[CW-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
      end else begin
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end

   assign column = col_ff;

   a_col_in_range: assert property (@(posedge clock) disable iff (reset)
      (CW+1)'(col_ff) < (CW+1)'(MAX_WIDTH))
      else $error("column counter beyond line store depth");

   a_frame_wrap: assert property (@(posedge clock) disable iff (reset)
      advance && flags.frame_end |=> col_ff == '0 && row_ff == '0)
      else $error("counters did not wrap at frame end");

   a_col_step: assert property (@(posedge clock) disable iff (reset)
      advance && !flags.row_end |=> col_ff == $past(col_ff) + CW'(1)
                                    && row_ff == $past(row_ff))
      else $error("column counter did not step by one");

endmodule : egs_raster_ctr
`default_nettype wire

/* rtl/core/emboss_gray_stream_unit.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// emboss_gray_stream_unit
// streaming upper-left difference emboss filter on 32-bit rgba pixels
// ----------------------------------------------------------------------------
// Takes one raster-order rgba pixel per clock while req_ready is high and
// gives one embossed pixel per pixel, in order. The line store, a single-port
// memory of MAX_WIDTH rgb entries, is read (old value) and written (new value)
// once per item at the current column. The old value read there becomes the
// upper-left neighbour of the next item, so no interlock is needed. Pixels on
// the first row or first column come out as gray 128; others take the
// largest-magnitude neighbour-minus-pixel channel difference plus 128,
// clamped to 0..255, in r, g and b, with alpha copied. rsp_frame_last marks
// the last pixel of a frame. The line store has no clearing pass; its entries
// are only read after being written during normal raster traffic.
// image_width (offset 0) and image_height (offset 4) are written over the
// apb-style port; 0 acts as 1 and values past the limits saturate; the user
// must write them only while the stream is idle, as the block does not check.
// ----------------------------------------------------------------------------
module emboss_gray_stream_unit
   import egs_pkg::*;
#(
   parameter int MAX_WIDTH = DEFAULT_MAX_WIDTH
) (
   input  wire logic                  clock,
   input  wire logic                  reset,

   // input item channel
   input  wire logic                  req_valid,
   output logic                       req_ready,
   input  wire logic [PIXEL_W-1:0]    req_pixel_in,

   // result item channel
   output logic                       rsp_valid,
   input  wire logic                  rsp_ready,
   output logic      [PIXEL_W-1:0]    rsp_pixel_out,
   output logic                       rsp_frame_last,

   // configuration port
   input  wire logic                  psel,
   input  wire logic                  penable,
   input  wire logic                  pwrite,
   input  wire logic [CSR_ADDR_W-1:0] paddr,
   input  wire logic [CSR_DATA_W-1:0] pwdata,
   output logic      [CSR_DATA_W-1:0] prdata,
   output logic                       pready
);

   localparam int CW = $clog2(MAX_WIDTH);

   // configuration registers
   logic [WIDTH_REG_W-1:0]  width_ff, width_in;
   logic [HEIGHT_REG_W-1:0] height_ff, height_in;
   reg_index_type           csr_index;
   logic                    csr_write;

   // stream control
   logic                    accept;
   logic [CW-1:0]           column;
   raster_flags_type        flags;
   logic [RGB_W-1:0]        upper_left_rgb;
   logic [CHAN_W-1:0]       gray;

   // result register
   logic                    out_valid_ff, out_valid_in;
   logic [PIXEL_W-1:0]      pixel_out_ff, pixel_out_in;
   logic                    frame_last_ff, frame_last_in;

   // ------------------------------------------------------------------------
   // configuration port: always ready, write on the access phase
   // ------------------------------------------------------------------------
   assign pready    = 1'b1;
   assign csr_index = reg_index_type'(paddr[2]);
   assign csr_write = psel && penable && pwrite && pready;

   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      if (csr_write) begin
         case (csr_index)
            REG_IMAGE_WIDTH:  width_in  = pwdata[WIDTH_REG_W-1:0];
            REG_IMAGE_HEIGHT: height_in = pwdata[HEIGHT_REG_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_index)
         REG_IMAGE_WIDTH:  prdata = CSR_DATA_W'(width_ff);
         REG_IMAGE_HEIGHT: prdata = CSR_DATA_W'(height_ff);
         default:          prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= WIDTH_RESET;
         height_ff <= HEIGHT_RESET;
      end else begin
         width_ff  <= width_in;
         height_ff <= height_in;
      end
   end

   // ------------------------------------------------------------------------
   // input side: take an item whenever the result register is free or leaving
   // ------------------------------------------------------------------------
   assign req_ready = !out_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;

   // raster position of the item being accepted
   egs_raster_ctr #(
      .MAX_WIDTH (MAX_WIDTH)
   ) u_raster_ctr (
      .clock        (clock),
      .reset        (reset),
      .advance      (accept),
      .image_width  (width_ff),
      .image_height (height_ff),
      .column       (column),
      .flags        (flags)
   );

   // line store: the entry above this column comes back as the upper-left
   // neighbour of the next item
   egs_line_store #(
      .MAX_WIDTH (MAX_WIDTH)
   ) u_line_store (
      .clock (clock),
      .access(accept),
      .addr  (column),
      .wdata (req_pixel_in[PIXEL_W-1:CHAN_W]),
      .rdata (upper_left_rgb)
   );

   // difference pick, offset and clamp
   egs_gray_calc u_gray_calc (
      .neighbour_rgb (upper_left_rgb),
      .pixel_rgb     (req_pixel_in[PIXEL_W-1:CHAN_W]),
      .border        (flags.border),
      .gray          (gray)
   );

   // ------------------------------------------------------------------------
   // result register
   // ------------------------------------------------------------------------
   always_comb begin
      out_valid_in  = out_valid_ff;
      pixel_out_in  = pixel_out_ff;
      frame_last_in = frame_last_ff;
      if (accept) begin
         out_valid_in  = 1'b1;
         pixel_out_in  = {gray, gray, gray, req_pixel_in[CHAN_W-1:0]};
         frame_last_in = flags.frame_end;
      end else if (rsp_ready) begin
         out_valid_in  = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pixel_out_ff  <= pixel_out_in;
      frame_last_ff <= frame_last_in;
   end

   assign rsp_valid      = out_valid_ff;
   assign rsp_pixel_out  = pixel_out_ff;
   assign rsp_frame_last = frame_last_ff;

   // ------------------------------------------------------------------------
   // assertions
   // ------------------------------------------------------------------------
   a_result_follows: assert property (@(posedge clock) disable iff (reset)
      accept |=> rsp_valid && rsp_pixel_out[CHAN_W-1:0] == $past(req_pixel_in[CHAN_W-1:0]))
      else $error("accepted item did not reach the result register");

   a_border_gray: assert property (@(posedge clock) disable iff (reset)
      accept && flags.border |=> rsp_pixel_out[PIXEL_W-1:CHAN_W] == {3{GRAY_MID}})
      else $error("first row or column pixel not mid gray");

   a_gray_channels: assert property (@(posedge clock) disable iff (reset)
      accept |=> rsp_pixel_out[31:24] == rsp_pixel_out[23:16]
                 && rsp_pixel_out[23:16] == rsp_pixel_out[15:8])
      else $error("gray channels differ");

endmodule : emboss_gray_stream_unit
`default_nettype wire

/* dv/egs_emboss_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// egs_emboss_checker
// predicts the embossed pixel stream and scores the result channel in order
// ----------------------------------------------------------------------------
module egs_emboss_checker
   import egs_pkg::*;
#(
   parameter int MAX_WIDTH = DEFAULT_MAX_WIDTH
) (
   input  wire logic                  clock,
   input  wire logic                  reset,

   input  wire logic                  req_valid,
   input  wire logic                  req_ready,
   input  wire logic [PIXEL_W-1:0]    req_pixel_in,

   input  wire logic                  rsp_valid,
   input  wire logic                  rsp_ready,
   input  wire logic [PIXEL_W-1:0]    rsp_pixel_out,
   input  wire logic                  rsp_frame_last,

   input  wire logic                  psel,
   input  wire logic                  penable,
   input  wire logic                  pwrite,
   input  wire logic [CSR_ADDR_W-1:0] paddr,
   input  wire logic [CSR_DATA_W-1:0] pwdata,
   input  wire logic                  pready,

   output int                         mismatch_count,
   output int                         pending_items
);

   localparam int COL_W = $clog2(MAX_WIDTH);

   typedef struct packed {
      logic [PIXEL_W-1:0] pixel;
      logic               last;
   } emboss_item_type;

   emboss_item_type gray_q[$];

   // shadow of the block's registers and raster state
   logic [WIDTH_REG_W-1:0]  width_reg;
   logic [HEIGHT_REG_W-1:0] height_reg;
   logic [RGB_W-1:0]        line_rgb [MAX_WIDTH];
   logic [RGB_W-1:0]        upper_left;
   logic [COL_W-1:0]        col_pos;
   logic [ROW_W-1:0]        row_pos;

   // zero acts as one, anything past the limit saturates
   function automatic int clip_dim(int v, int hi);
      if (v == 0) return 1;
      if (v > hi) return hi;
      return v;
   endfunction

   function automatic int magnitude(int d);
      return (d < 0) ? -d : d;
   endfunction

   function automatic logic [CHAN_W-1:0] emboss_gray(logic [RGB_W-1:0] nb,
                                                     logic [PIXEL_W-1:0] px);
      int dr, dg, db, diff, g;
      dr = int'(nb[23:16]) - int'(px[31:24]);
      dg = int'(nb[15:8]) - int'(px[23:16]);
      db = int'(nb[7:0]) - int'(px[15:8]);
      // red beats green beats blue on equal magnitude
      if (magnitude(dr) >= magnitude(dg) && magnitude(dr) >= magnitude(db)) diff = dr;
      else if (magnitude(dg) >= magnitude(db)) diff = dg;
      else diff = db;
      g = int'(GRAY_MID) + diff;
      if (g < 0) g = 0;
      if (g > int'(GRAY_MAX)) g = int'(GRAY_MAX);
      return CHAN_W'(g);
   endfunction

   function automatic emboss_item_type predict_emboss(logic [PIXEL_W-1:0] px);
      int                w, h;
      logic              row_end, frame_end;
      logic [CHAN_W-1:0] g;
      emboss_item_type   res;
      w = clip_dim(int'(width_reg), MAX_WIDTH);
      h = clip_dim(int'(height_reg), int'(MAX_HEIGHT));
      // a counter at or past a shrunken bound counts as the last position
      row_end   = (int'(col_pos) + 1 >= w);
      frame_end = row_end && (int'(row_pos) + 1 >= h);
      if (row_pos == '0 || col_pos == '0) g = GRAY_MID;
      else g = emboss_gray(upper_left, px);
      upper_left        = line_rgb[col_pos];
      line_rgb[col_pos] = px[PIXEL_W-1:CHAN_W];
      if (row_end) begin
         col_pos = '0;
         row_pos = frame_end ? '0 : row_pos + 1'b1;
      end else begin
         col_pos = col_pos + 1'b1;
      end
      res.pixel = {g, g, g, px[CHAN_W-1:0]};
      res.last  = frame_end;
      return res;
   endfunction

   always @(posedge clock) begin : score
      emboss_item_type want;
      if (reset) begin
         width_reg  = WIDTH_RESET;
         height_reg = HEIGHT_RESET;
         upper_left = '0;
         col_pos    = '0;
         row_pos    = '0;
         foreach (line_rgb[i]) line_rgb[i] = '0;
         gray_q.delete();
      end else begin
         if (psel && penable && pwrite && pready) begin
            case (reg_index_type'(paddr[2]))
               REG_IMAGE_WIDTH: begin
                  width_reg = pwdata[WIDTH_REG_W-1:0];
               end
               REG_IMAGE_HEIGHT: begin
                  height_reg = pwdata[HEIGHT_REG_W-1:0];
               end
               default: ;
            endcase
         end
         // results leave before the same edge's item is predicted
         if (rsp_valid && rsp_ready) begin
            if (gray_q.size() == 0) begin
               mismatch_count++;
               $display("%0t unexpected item: expected none actual %08h/%0b",
                        $time, rsp_pixel_out, rsp_frame_last);
            end else begin
               want = gray_q.pop_front();
               if (rsp_pixel_out !== want.pixel) begin
                  mismatch_count++;
                  $display("%0t pixel_out: expected %08h actual %08h",
                           $time, want.pixel, rsp_pixel_out);
               end
               if (rsp_frame_last !== want.last) begin
                  mismatch_count++;
                  $display("%0t frame_last: expected %0b actual %0b",
                           $time, want.last, rsp_frame_last);
               end
            end
         end
         if (req_valid && req_ready) gray_q.push_back(predict_emboss(req_pixel_in));
      end
      pending_items <= gray_q.size();
   end

endmodule : egs_emboss_checker

/* dv/tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// stimulus and verdict for the emboss gray stream unit
// ----------------------------------------------------------------------------
// Drives raster pixel frames under several width and height settings, with
// random gaps on the input side and random stalls on the result side, and
// lets the checker predict and compare every item. A full-width frame early
// on fills the whole line store, so later mid-frame register changes never
// expose an unwritten entry.
// ----------------------------------------------------------------------------
module tb;
   import egs_pkg::*;

   localparam int MAX_W        = DEFAULT_MAX_WIDTH;
   localparam int RANDOM_ITEMS = 700;
   localparam int HOLD_CYCLES  = 160;   // long result-side hold-off
   localparam int STALL_LIMIT  = 2000;  // cycles with no item moving
   localparam int DRAIN_CYCLES = 8;

   logic                  clock;
   logic                  reset          = 1'b1;

   logic                  req_valid      = 1'b0;
   logic                  req_ready;
   logic [PIXEL_W-1:0]    req_pixel_in   = '0;

   logic                  rsp_valid;
   logic                  rsp_ready      = 1'b0;
   logic [PIXEL_W-1:0]    rsp_pixel_out;
   logic                  rsp_frame_last;

   logic                  psel           = 1'b0;
   logic                  penable        = 1'b0;
   logic                  pwrite         = 1'b0;
   logic [CSR_ADDR_W-1:0] paddr          = '0;
   logic [CSR_DATA_W-1:0] pwdata         = '0;
   logic [CSR_DATA_W-1:0] prdata;
   logic                  pready;

   int mismatch_count;
   int pending_items;

   // idle rates in percent, changed per phase by the stimulus
   int tx_idle_pct = 12;
   int rx_idle_pct = 49;
   int hold_req    = 0;
   int items_sent  = 0;

   // directed 4x3 frame: clamp high, clamp low, red/green tie of opposite
   // sign, green winning, green/blue tie, blue winning
   logic [PIXEL_W-1:0] corner_px [12] = '{
      32'hFFFFFF00, 32'h000000FF, 32'h8040C05A, 32'h01020304,
      32'h11223344, 32'h0000007F, 32'hFFFFFF80, 32'h6060C0A5,
      32'hC3C3C3C3, 32'h1172433C, 32'h05404000, 32'hF0E010D2
   };

   emboss_gray_stream_unit #(
      .MAX_WIDTH (MAX_W)
   ) dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_pixel_in   (req_pixel_in),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_pixel_out  (rsp_pixel_out),
      .rsp_frame_last (rsp_frame_last),
      .psel           (psel),
      .penable        (penable),
      .pwrite         (pwrite),
      .paddr          (paddr),
      .pwdata         (pwdata),
      .prdata         (prdata),
      .pready         (pready)
   );

   egs_emboss_checker #(
      .MAX_WIDTH (MAX_W)
   ) scoreboard (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_pixel_in   (req_pixel_in),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_pixel_out  (rsp_pixel_out),
      .rsp_frame_last (rsp_frame_last),
      .psel           (psel),
      .penable        (penable),
      .pwrite         (pwrite),
      .paddr          (paddr),
      .pwdata         (pwdata),
      .pready         (pready),
      .mismatch_count (mismatch_count),
      .pending_items  (pending_items)
   );

   // 4 ns clock
   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // result side: random stalls, plus a long hold-off when one is requested
   initial begin : receiver
      int hold_left;
      hold_left = 0;
      forever begin
         @(posedge clock);
         if (hold_req > 0) begin
            hold_left = hold_req;
            hold_req  = 0;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= ($urandom_range(99) >= rx_idle_pct);
         end
      end
   end

   // ends the run when no item moves on either channel for too long
   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < STALL_LIMIT) begin
         @(posedge clock);
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) quiet = 0;
         else quiet++;
      end
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   // one item on the input channel; valid drops only when a gap is taken
   task automatic push_pixel(input logic [PIXEL_W-1:0] px);
      if ($urandom_range(99) < tx_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid    <= 1'b1;
      req_pixel_in <= px;
      do @(posedge clock); while (!req_ready);
      items_sent++;
   endtask

   // stop offering items and wait until every predicted item has come out
   task automatic quiesce();
      req_valid <= 1'b0;
      do @(posedge clock); while (pending_items != 0);
   endtask

   // setup phase, access phase, then an idle phase
   task automatic csr_write(input reg_index_type idx, input logic [CSR_DATA_W-1:0] value);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {idx, 2'b00};
      pwdata  <= value;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      @(posedge clock);
   endtask

   // mostly random pixels, some pinned to the channel extremes, some drawn
   // from a small set of levels so equal magnitudes show up often
   function automatic logic [PIXEL_W-1:0] rand_pixel();
      logic [CHAN_W-1:0] chan [3];
      int                mode;
      mode = $urandom_range(99);
      if (mode < 55) return $urandom();
      foreach (chan[i]) begin
         if (mode < 80) begin
            case ($urandom_range(3))
               0:       chan[i] = 8'h00;
               1:       chan[i] = 8'hFF;
               default: chan[i] = CHAN_W'($urandom_range(255));
            endcase
         end else begin
            case ($urandom_range(2))
               0:       chan[i] = 8'h40;
               1:       chan[i] = 8'h80;
               default: chan[i] = 8'hC0;
            endcase
         end
      end
      return {chan[0], chan[1], chan[2], CHAN_W'($urandom_range(255))};
   endfunction

   // random frame geometries; each segment waits for the block to drain,
   // rewrites both registers, then sends frames (cut when long) or a broken piece
   task automatic random_traffic(input int count);
      int target, pick, w, h, we, he, n;
      target = items_sent + count;
      while (items_sent < target) begin
         pick = $urandom_range(99);
         if (pick < 65) w = $urandom_range(8, 1);
         else if (pick < 88) w = $urandom_range(40, 9);
         else if (pick < 94) w = $urandom_range(200, 41);
         else begin
            case ($urandom_range(3))
               0:       w = 0;
               1:       w = MAX_W;
               2:       w = MAX_W + 1;
               default: w = 2047;
            endcase
         end
         pick = $urandom_range(99);
         if (pick < 70) h = $urandom_range(5, 1);
         else if (pick < 88) h = $urandom_range(16, 6);
         else if (pick < 94) h = 0;
         else begin
            case ($urandom_range(2))
               0:       h = int'(MAX_HEIGHT);
               1:       h = 8191;
               default: h = $urandom_range(8191, int'(MAX_HEIGHT) + 1);
            endcase
         end
         we = (w == 0) ? 1 : ((w > MAX_W) ? MAX_W : w);
         he = (h == 0) ? 1 : ((h > int'(MAX_HEIGHT)) ? int'(MAX_HEIGHT) : h);

         quiesce();
         csr_write(REG_IMAGE_WIDTH, w);
         csr_write(REG_IMAGE_HEIGHT, h);

         // broken frames leave the counters mid-frame for the next rewrite
         if ($urandom_range(99) < 15) n = $urandom_range(20, 1);
         else n = we * he * $urandom_range(2, 1);
         if (n > 300) n = $urandom_range(300, 60);
         if (n > target - items_sent) n = target - items_sent;
         repeat (n) push_pixel(rand_pixel());
      end
   endtask

   initial begin : stimulus
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // small frame with the difference corner cases
      csr_write(REG_IMAGE_WIDTH, 4);
      csr_write(REG_IMAGE_HEIGHT, 3);
      foreach (corner_px[i]) push_pixel(corner_px[i]);

      // full-width frame, width saturating, under a long result hold-off
      // so the block backs up and stalls its input
      quiesce();
      csr_write(REG_IMAGE_WIDTH, 2047);
      csr_write(REG_IMAGE_HEIGHT, 1);
      hold_req = HOLD_CYCLES;
      repeat (MAX_W) push_pixel(rand_pixel());

      // zero width and height act as one
      quiesce();
      csr_write(REG_IMAGE_WIDTH, 0);
      csr_write(REG_IMAGE_HEIGHT, 0);
      repeat (2) push_pixel(rand_pixel());

      // upper write-data bits ignored: width 2, height saturating
      quiesce();
      csr_write(REG_IMAGE_WIDTH, 32'hFFFF_F802);
      csr_write(REG_IMAGE_HEIGHT, 32'hFFFF_FFFF);
      repeat (4) push_pixel(rand_pixel());

      // now at row 2 column 0: widen, stop at column 3, shrink width below
      // the column so this position ends its row
      quiesce();
      csr_write(REG_IMAGE_WIDTH, 8);
      repeat (3) push_pixel(rand_pixel());
      quiesce();
      csr_write(REG_IMAGE_WIDTH, 2);
      push_pixel(rand_pixel());
      // row 3: shrink height below the row so this row ends the frame
      quiesce();
      csr_write(REG_IMAGE_HEIGHT, 2);
      repeat (2) push_pixel(rand_pixel());

      // random frames under three idle mixes
      random_traffic(RANDOM_ITEMS / 3);
      tx_idle_pct = 49;
      rx_idle_pct = 12;
      random_traffic(RANDOM_ITEMS / 3);
      tx_idle_pct = 0;
      rx_idle_pct = 0;
      random_traffic(RANDOM_ITEMS - 2 * (RANDOM_ITEMS / 3));

      quiesce();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule : tb
